// ===== hdl/psp_pkg.sv =====
package psp_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SPLAT = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_ROW0   = 3'd0,
      REG_ROW1   = 3'd1,
      REG_ROW2   = 3'd2,
      REG_PIVX   = 3'd3,
      REG_PIVY   = 3'd4,
      REG_PIVZ   = 3'd5,
      REG_ZOOM   = 3'd6,
      REG_FRAME  = 3'd7
   } reg_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [17:0]        pixel_addr;
   } req_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       landed;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        row0;
      logic [47:0]        row1;
      logic [47:0]        row2;
      logic signed [23:0] pivot_x;
      logic signed [23:0] pivot_y;
      logic signed [23:0] pivot_z;
      logic [23:0]        zoom;
      logic [25:0]        frame_size;
   } cfg_type;

   // pixel increments
   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } inc_type;

endpackage

// ===== hdl/psp_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module psp_divider import psp_pkg::*; #(
   parameter int NW = 56,
   parameter int DW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic        [DW-1:0] den,
   output logic                 done,
   output logic signed [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [NW-1:0] mag;

   always_comb begin
      mag     = num[NW-1] ? NW'(-num) : NW'(num);
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in    = mag;
         r_in    = '0;
         d_in    = den;
         neg_in  = num[NW-1];
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? NW'(-$signed(q_ff)) : $signed(q_ff);
endmodule

// ===== hdl/psp_frame_store.sv =====
// Frame store: one write port, one registered read port.
module psp_frame_store import psp_pkg::*; #(
   parameter int AW = 18
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data
);
   logic [23:0] mem [2**AW];
   logic [23:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== hdl/point_splat_projector_top.sv =====
// Channel  Direction  Word
// req      in         opcode, pos_x/y/z, pixel_addr
// rsp      out        blue, green, red, landed
// csr      in         register index, write data
// Splat: the bit-serial divider dominates each item. It runs for x and again for y,
// then a store read-modify-write follows.
// Read: one registered store read. A point with depth below 10 is dropped before the divider.
// Clear: writes MAX_WIDTH*MAX_HEIGHT pixels, one pixel a cycle. The same pass runs after
// reset before req_ready rises. csr writes are taken at all times.
// A stalled rsp holds the result in its register and keeps req_ready low.
module point_splat_projector_top import psp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = 60;
   localparam int DW    = 35;
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int HB    = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MUL, S_SUM, S_NUMX, S_DIVX, S_NUMY, S_DIVY, S_CHECK, S_RD,
      S_WR, S_READ, S_READ2, S_RSP
   } state_type;

   state_type   st_ff, st_in;
   cfg_type     cfg_ff;
   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic [AW:0] clr_ff, clr_in;
   logic        boot_ff, boot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row0       <= 48'd16384;
         cfg_ff.row1       <= 48'd1073741824;
         cfg_ff.row2       <= 48'd70368744177664;
         cfg_ff.pivot_x    <= '0;
         cfg_ff.pivot_y    <= '0;
         cfg_ff.pivot_z    <= '0;
         cfg_ff.zoom       <= 24'd76800;
         cfg_ff.frame_size <= 26'd33554944;
      end else if (csr_valid) begin
         case (reg_type'(csr_index))
            REG_ROW0:  cfg_ff.row0       <= csr_data;
            REG_ROW1:  cfg_ff.row1       <= csr_data;
            REG_ROW2:  cfg_ff.row2       <= csr_data;
            REG_PIVX:  cfg_ff.pivot_x    <= csr_data[23:0];
            REG_PIVY:  cfg_ff.pivot_y    <= csr_data[23:0];
            REG_PIVZ:  cfg_ff.pivot_z    <= csr_data[23:0];
            REG_ZOOM:  cfg_ff.zoom       <= csr_data[23:0];
            REG_FRAME: cfg_ff.frame_size <= csr_data[25:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // frame geometry, saturated
   logic [WB-1:0] w_sat;
   logic [HB-1:0] h_sat;
   always_comb begin
      w_sat = ({22'd0, cfg_ff.frame_size[9:0]} > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH)
            : WB'(cfg_ff.frame_size[9:0]);
      h_sat = ({22'd0, cfg_ff.frame_size[25:16]} > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT)
            : HB'(cfg_ff.frame_size[25:16]);
   end

   // zoom*k/76800 is (zoom >> s)/15; below 3840, t*4370 >> 16 equals t/15
   function automatic logic [7:0] inc_div(input logic [15:0] t);
      logic [31:0] p;
      p       = 32'(t) * 32'd4370;
      inc_div = (t >= 16'd3840) ? 8'd255 : p[23:16];
   endfunction

   inc_type inc;
   always_comb begin
      if (cfg_ff.zoom < 24'd38400) begin
         inc.b = 8'd2; inc.g = 8'd5; inc.r = 8'd10;
      end else begin
         inc.b = inc_div(16'(cfg_ff.zoom[23:10]));
         inc.g = inc_div(16'(cfg_ff.zoom[23:9]));
         inc.r = inc_div(cfg_ff.zoom[23:8]);
      end
   end

   // rotation: nine products registered, then summed
   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic signed [40:0] p_ff [9];
   logic signed [42:0] s_x, s_y, s_z;
   logic signed [28:0] rx_ff, ry_ff, fz_ff;

   function automatic logic signed [15:0] cf(input logic [47:0] row, input int c);
      cf = row[16*c +: 16];
   endfunction

   always_ff @(posedge clock) begin
      if (st_ff == S_IDLE) begin
         dx_ff <= 25'(req_data.pos_x) - 25'(cfg_ff.pivot_x);
         dy_ff <= 25'(req_data.pos_y) - 25'(cfg_ff.pivot_y);
         dz_ff <= 25'(req_data.pos_z) - 25'(cfg_ff.pivot_z);
      end
      if (st_ff == S_MUL) begin
         p_ff[0] <= dx_ff * cf(cfg_ff.row0, 0);
         p_ff[1] <= dy_ff * cf(cfg_ff.row0, 1);
         p_ff[2] <= dz_ff * cf(cfg_ff.row0, 2);
         p_ff[3] <= dx_ff * cf(cfg_ff.row1, 0);
         p_ff[4] <= dy_ff * cf(cfg_ff.row1, 1);
         p_ff[5] <= dz_ff * cf(cfg_ff.row1, 2);
         p_ff[6] <= dx_ff * cf(cfg_ff.row2, 0);
         p_ff[7] <= dy_ff * cf(cfg_ff.row2, 1);
         p_ff[8] <= dz_ff * cf(cfg_ff.row2, 2);
      end
      if (st_ff == S_SUM) begin
         rx_ff <= 29'(s_x >>> 14);
         ry_ff <= 29'(s_y >>> 14);
         fz_ff <= 29'(s_z >>> 14) + 29'sd256000;
      end
   end

   always_comb begin
      s_x = 43'(p_ff[0]) + 43'(p_ff[1]) + 43'(p_ff[2]);
      s_y = 43'(p_ff[3]) + 43'(p_ff[4]) + 43'(p_ff[5]);
      s_z = 43'(p_ff[6]) + 43'(p_ff[7]) + 43'(p_ff[8]);
   end

   // numerator: r*zoom + half*fz*256, x in S_NUMX and y in S_NUMY
   logic signed [NW-1:0] num_ff;
   logic                 dstart_ff;
   logic                 ddone;
   logic signed [NW-1:0] dquot;
   logic signed [NW-1:0] sx_ff;
   logic [DW-1:0]        den;
   logic signed [28:0]   r_sel;
   logic [15:0]          half;
   logic signed [53:0]   prod_r;
   logic signed [45:0]   prod_h;

   assign den = DW'(fz_ff) << 8;
   always_comb begin
      r_sel  = (st_ff == S_NUMX) ? rx_ff : ry_ff;
      half   = (st_ff == S_NUMX) ? 16'(w_sat >> 1) : 16'(h_sat >> 1);
      prod_r = r_sel * $signed({1'b0, cfg_ff.zoom});
      prod_h = $signed({1'b0, half}) * fz_ff;
   end

   psp_divider #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(dstart_ff), .num(num_ff), .den(den),
      .done(ddone), .quot(dquot)
   );

   // store
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [23:0]   wr_data, rd_data;
   logic [AW-1:0] idx_ff;

   psp_frame_store #(.AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic          on_screen;
   logic [AW-1:0] idx_full;
   always_comb begin
      on_screen = (sx_ff >= 0) && (sx_ff < NW'(w_sat)) && (dquot >= 0)
                && (dquot < NW'(h_sat));
      idx_full  = AW'(dquot[HB-1:0]) * AW'(w_sat) + AW'(sx_ff[WB-1:0]);
   end

   always_comb begin
      st_in   = st_ff;
      rsp_in  = rsp_ff;
      clr_in  = clr_ff;
      boot_in = boot_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {rd_data[23:16] + inc.b, rd_data[15:8] + inc.g, rd_data[7:0] + inc.r};
      rd_addr = idx_ff;
      case (st_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) begin
               // the pass after reset owes no word
               st_in   = boot_ff ? S_IDLE : S_RSP;
               boot_in = 1'b0;
            end
         end
         S_IDLE: if (req_valid) begin
            rsp_in = '0;
            case (op_type'(req_data.opcode))
               OP_CLEAR: begin clr_in = '0; st_in = S_CLEAR; end
               OP_SPLAT: st_in = S_MUL;
               OP_READ:  st_in = S_READ;
               default:  st_in = S_RSP;
            endcase
         end
         S_MUL:   st_in = S_SUM;
         S_SUM:   st_in = S_NUMX;
         S_NUMX:  st_in = (fz_ff < 29'sd2560) ? S_RSP : S_DIVX;
         S_DIVX:  if (ddone) st_in = S_NUMY;
         S_NUMY:  st_in = S_DIVY;
         S_DIVY:  if (ddone) st_in = S_CHECK;
         S_CHECK: st_in = on_screen ? S_RD : S_RSP;
         S_RD:    st_in = S_WR;
         S_WR: begin
            wr_en  = 1'b1;
            rsp_in.landed = 1'b1;
            st_in  = S_RSP;
         end
         S_READ: begin
            rd_addr = req_ff.pixel_addr[AW-1:0];
            st_in   = S_READ2;
         end
         S_READ2: begin
            if (32'(req_ff.pixel_addr) < 32'(DEPTH)) begin
               rsp_in.blue  = rd_data[23:16];
               rsp_in.green = rd_data[15:8];
               rsp_in.red   = rd_data[7:0];
            end
            st_in = S_RSP;
         end
         S_RSP:   if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_CLEAR;
         clr_ff    <= '0;
         boot_ff   <= 1'b1;
         dstart_ff <= 1'b0;
         rsp_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         clr_ff    <= clr_in;
         boot_ff   <= boot_in;
         rsp_ff    <= rsp_in;
         dstart_ff <= ((st_ff == S_NUMX) && (fz_ff >= 29'sd2560)) || (st_ff == S_NUMY);
      end
      if (st_ff == S_IDLE) req_ff <= req_data;
      if (st_ff == S_NUMX || st_ff == S_NUMY)
         num_ff <= NW'(prod_r) + (NW'(prod_h) <<< 8);
      if (st_ff == S_DIVX && ddone) sx_ff <= dquot;
      if (st_ff == S_CHECK) idx_ff <= idx_full;
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = (st_ff == S_RSP);
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CLEAR |-> !req_ready) else $error("ready during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_land_splat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.landed |-> req_ff.opcode == OP_SPLAT) else $error("bad landed");
`endif
endmodule

// ===== verif/tb.sv =====
module tb;
   import psp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam longint LIMIT = 64'd60_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_data = '0;

   point_splat_projector_top uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the block's registers and frame store
   logic [47:0]        rot [3];
   logic signed [23:0] piv [3];
   logic [23:0]        zoom_q;
   logic [25:0]        fsize;
   logic [23:0]        pixels [STORE_DEPTH];

   rsp_type pending_pixels [$];
   int      mismatches = 0;
   int      send_idle = 0;
   int      recv_idle = 0;
   longint  cycles = 0;

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
      return q;
   endfunction

   function automatic longint rotate_row(logic [47:0] row, longint dx, longint dy,
                                         longint dz);
      longint c0, c1, c2;
      c0 = longint'($signed(row[15:0]));
      c1 = longint'($signed(row[31:16]));
      c2 = longint'($signed(row[47:32]));
      return floor_div(dx * c0 + dy * c1 + dz * c2, 16384);
   endfunction

   function automatic logic [7:0] brightness(longint mult);
      longint v;
      if (zoom_q < 24'd38400) v = mult / 2;
      else v = mult * longint'(zoom_q) / 76800;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic rsp_type apply_item(req_type r);
      rsp_type o;
      longint  w, h, dx, dy, dz, rx, ry, fz, sx, sy, idx;
      o = '0;
      case (op_type'(r.opcode))
         OP_CLEAR: for (int i = 0; i < STORE_DEPTH; i++) pixels[i] = '0;
         OP_READ: if (r.pixel_addr < STORE_DEPTH) begin
            o.blue  = pixels[r.pixel_addr][23:16];
            o.green = pixels[r.pixel_addr][15:8];
            o.red   = pixels[r.pixel_addr][7:0];
         end
         OP_SPLAT: begin
            w = fsize[9:0];
            h = fsize[25:16];
            if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
            dx = longint'(r.pos_x) - longint'(piv[0]);
            dy = longint'(r.pos_y) - longint'(piv[1]);
            dz = longint'(r.pos_z) - longint'(piv[2]);
            rx = rotate_row(rot[0], dx, dy, dz);
            ry = rotate_row(rot[1], dx, dy, dz);
            fz = rotate_row(rot[2], dx, dy, dz) + 1000 * 256;
            if (fz >= 10 * 256) begin
               sx = (rx * longint'(zoom_q) + (w / 2) * fz * 256) / (fz * 256);
               sy = (ry * longint'(zoom_q) + (h / 2) * fz * 256) / (fz * 256);
               if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
                  idx = sy * w + sx;
                  pixels[idx][23:16] += brightness(5);
                  pixels[idx][15:8]  += brightness(10);
                  pixels[idx][7:0]   += brightness(20);
                  o.landed = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic write_reg(reg_type idx, logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ROW0:  rot[0] = value;
         REG_ROW1:  rot[1] = value;
         REG_ROW2:  rot[2] = value;
         REG_PIVX:  piv[0] = value[23:0];
         REG_PIVY:  piv[1] = value[23:0];
         REG_PIVZ:  piv[2] = value[23:0];
         REG_ZOOM:  zoom_q = value[23:0];
         REG_FRAME: fsize = value[25:0];
         default: ;
      endcase
   endtask

   // hold valid until the edge that takes the word; drop it only to idle
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(apply_item(r));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type mk(op_type op, int x, int y, int z, int a);
      req_type r;
      r.opcode = op;
      r.pos_x = 24'(x);
      r.pos_y = 24'(y);
      r.pos_z = 24'(z);
      r.pixel_addr = 18'(a);
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      k;
      r = 92'({$urandom, $urandom, $urandom});
      r.pos_x = 24'($urandom);
      k = $urandom_range(99);
      if (k < 1) r.opcode = OP_CLEAR;
      else if (k < 3) r.opcode = OP_NONE;
      else if (k < 60) r.opcode = OP_SPLAT;
      else r.opcode = OP_READ;
      if (r.opcode == OP_SPLAT && $urandom_range(9) < 8) begin
         // keep points near the view so most land
         r.pos_x = 24'($signed($urandom_range(200000)) - 100000);
         r.pos_y = 24'($signed($urandom_range(200000)) - 100000);
         r.pos_z = 24'($signed($urandom_range(400000)) - 200000);
      end
      if (r.opcode == OP_READ && $urandom_range(9) < 8)
         r.pixel_addr = 18'($urandom_range(MAX_WIDTH_DEF * 64));
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_data);
         end else begin
            if (rsp_data.blue !== pending_pixels[0].blue
                || rsp_data.green !== pending_pixels[0].green
                || rsp_data.red !== pending_pixels[0].red
                || rsp_data.landed !== pending_pixels[0].landed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h got %h", pending_pixels[0], rsp_data);
            end
            void'(pending_pixels.pop_front());
         end
      end
   end

   typedef struct {
      req_type r;
      logic    known;
      rsp_type o;
   } row_type;

   row_type directed [$];

   initial begin
      rot[0] = 48'd16384;
      rot[1] = 48'd1073741824;
      rot[2] = 48'd70368744177664;
      piv = '{default: '0};
      zoom_q = 24'd76800;
      fsize = 26'd33554944;
      for (int i = 0; i < STORE_DEPTH; i++) pixels[i] = '0;

      directed.push_back('{mk(OP_READ, 0, 0, 0, 0), 1, '0});
      directed.push_back('{mk(OP_READ, 0, 0, 0, 262143), 1, '0});
      directed.push_back('{mk(OP_SPLAT, 0, 0, 0, 0), 1, '{0, 0, 0, 1}});
      directed.push_back('{mk(OP_READ, 0, 0, 0, 256 * 512 + 256), 1, '{5, 10, 20, 0}});
      directed.push_back('{mk(OP_SPLAT, 8388607, 8388607, 8388607, 0), 0, '0});
      directed.push_back('{mk(OP_SPLAT, -8388608, -8388608, -8388608, 0), 1, '0});
      directed.push_back('{mk(OP_SPLAT, 0, 0, -253441, 0), 1, '0});
      directed.push_back('{mk(OP_SPLAT, 0, 0, -253440, 0), 0, '0});
      directed.push_back('{mk(OP_SPLAT, -40000, 30000, 5000, 0), 0, '0});
      directed.push_back('{mk(OP_NONE, -1, -1, -1, 262143), 1, '0});
      directed.push_back('{mk(OP_CLEAR, 0, 0, 0, 0), 1, '0});
      directed.push_back('{mk(OP_READ, 0, 0, 0, 256 * 512 + 256), 1, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_item(directed[i].r);
         if (directed[i].known && pending_pixels[$] !== directed[i].o) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row %0d exp %h model %h", i, directed[i].o,
                        pending_pixels[$]);
         end
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle = (phase % 3 == 0) ? 9 : (phase % 3 == 1) ? 76 : 0;
         recv_idle = (phase % 3 == 0) ? 76 : (phase % 3 == 1) ? 9 : 0;
         case (phase)
            1: begin
               write_reg(REG_ZOOM, 48'hFFFFFF);
               write_reg(REG_FRAME, 48'h3FF03FF);
               write_reg(REG_PIVX, 48'h800000);
               write_reg(REG_PIVY, 48'h7FFFFF);
            end
            2: begin
               write_reg(REG_ZOOM, 48'd0);
               write_reg(REG_FRAME, 48'd0);
               write_reg(REG_PIVX, 48'd0);
               write_reg(REG_PIVY, 48'd0);
            end
            3: begin
               write_reg(REG_ROW0, {16'h0000, 16'h2D41, 16'h2D41});
               write_reg(REG_ROW1, {16'h0000, 16'h2D41, 16'hD2BF});
               write_reg(REG_ROW2, {16'h4000, 16'h0000, 16'h0000});
               write_reg(REG_PIVZ, 48'hFF0000);
               write_reg(REG_ZOOM, 48'd38399);
               write_reg(REG_FRAME, 48'h0100_0080);
            end
            4: begin
               write_reg(REG_ROW0, 48'hFFFF_FFFF_FFFF);
               write_reg(REG_ROW1, 48'h8000_7FFF_8000);
               write_reg(REG_ROW2, 48'h0000_0000_4000);
               write_reg(REG_PIVZ, 48'h000000);
               write_reg(REG_ZOOM, 48'd38400);
               write_reg(REG_FRAME, 48'h0001_0001);
            end
            5: begin
               write_reg(REG_ROW0, 48'd16384);
               write_reg(REG_ROW1, 48'd1073741824);
               write_reg(REG_ROW2, 48'd70368744177664);
               write_reg(REG_ZOOM, 48'd76800);
               write_reg(REG_FRAME, 48'h0200_0200);
            end
            default: ;
         endcase
         for (int i = 0; i < 250; i++) begin
            send_item(random_item());
            // hold off until the store has caught up
            if (phase == 0 && i == 100) drain();
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/psp_pkg.sv
hdl/psp_divider.sv
hdl/psp_frame_store.sv
hdl/point_splat_projector_top.sv
verif/tb.sv
